// File: hw/rtl/button_press_hold_detector_core_assert.svh
// Assertion macros for the detector RTL.
`ifndef BUTTON_PRESS_HOLD_DETECTOR_CORE_ASSERT_SVH
`define BUTTON_PRESS_HOLD_DETECTOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define BPHD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BPHD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BPHD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BPHD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: hw/rtl/bphd_pkg.sv
`default_nettype none

package bphd_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 3;

    // register index, taken from paddr[2]
    localparam logic REG_KEY_ENABLE = 1'b0;
    localparam logic REG_HOLD_MS    = 1'b1;

    typedef enum logic [2:0] {
        PH_EMPTY    = 3'd0,
        PH_PRESSED  = 3'd1,
        PH_TIMING   = 3'd2,
        PH_HOLD     = 3'd3,
        PH_RELEASED = 3'd4
    } phase_t;

    typedef struct packed {
        logic [DATA_W-1:0] key_code;
        phase_t            phase;
        logic [DATA_W-1:0] previous_code;
    } bphd_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/bphd_fsm.sv
`default_nettype none

`include "button_press_hold_detector_core_assert.svh"

module bphd_fsm (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        advance,
    input  wire logic [bphd_pkg::DATA_W-1:0] code,
    input  wire logic [bphd_pkg::DATA_W-1:0] now,
    input  wire logic [bphd_pkg::DATA_W-1:0] hold_ms,
    output bphd_pkg::bphd_state_t            state
);
    import bphd_pkg::*;

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [DATA_W-1:0] current_key_reg;
    logic [DATA_W-1:0] current_key_next;
    logic [DATA_W-1:0] last_key_reg;
    logic [DATA_W-1:0] last_key_next;
    logic [DATA_W-1:0] start_stamp_reg;
    logic [DATA_W-1:0] start_stamp_next;
    logic [DATA_W-1:0] elapsed;
    logic              code_none;
    logic              ph_empty;
    logic              ph_released;
    logic              key_none;
    logic              rel_step;
    logic              cleared;
    logic              timing_drop;

    assign elapsed   = now - start_stamp_reg;
    assign code_none = (code == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_EMPTY;
            current_key_reg <= '0;
            last_key_reg    <= '0;
            start_stamp_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg       <= phase_next;
            current_key_reg <= current_key_next;
            last_key_reg    <= last_key_next;
            start_stamp_reg <= start_stamp_next;
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        current_key_next = current_key_reg;
        last_key_next    = last_key_reg;
        start_stamp_next = start_stamp_reg;
        case (phase_reg)
            PH_EMPTY:
            begin
                if (!code_none)
                begin
                    last_key_next    = current_key_reg;
                    current_key_next = code;
                    phase_next       = PH_PRESSED;
                end
            end
            PH_PRESSED:
            begin
                if (!code_none && code == current_key_reg)
                begin
                    start_stamp_next = now;
                    phase_next       = PH_TIMING;
                end
                else
                begin
                    phase_next = PH_RELEASED;
                end
            end
            PH_TIMING:
            begin
                // a different nonzero key is ignored here; only release or an elapsed time past hold_ms leaves
                if (code_none)
                    phase_next = PH_RELEASED;
                else if (elapsed > hold_ms)
                    phase_next = PH_HOLD;
            end
            PH_HOLD:
            begin
                if (code_none)
                    phase_next = PH_RELEASED;
            end
            PH_RELEASED:
            begin
                last_key_next    = current_key_reg;
                current_key_next = '0;
                phase_next       = PH_EMPTY;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    assign state.key_code      = current_key_reg;
    assign state.phase         = phase_reg;
    assign state.previous_code = last_key_reg;

    assign ph_empty    = (phase_reg == PH_EMPTY);
    assign ph_released = (phase_reg == PH_RELEASED);
    assign key_none    = (current_key_reg == '0);
    assign rel_step    = advance && ph_released;
    assign cleared     = ph_empty && key_none;
    assign timing_drop = advance && (phase_reg == PH_TIMING) && code_none;

    `BPHD_ASSERT_IMP(a_empty_key, clk, rst_n, 1'b1, ph_empty == key_none, "key set while empty")
    `BPHD_ASSERT_NXT(a_release_clears, clk, rst_n, rel_step, cleared, "release kept the key")
    `BPHD_ASSERT_NXT(a_hold_on_stall, clk, rst_n, !advance, $stable(state), "moved on a stall")
    `BPHD_ASSERT_NXT(a_timing_rel, clk, rst_n, timing_drop, ph_released, "timing release missed")

endmodule

`default_nettype wire

// File: hw/rtl/button_press_hold_detector_core.sv
// Button press / hold / release detector.
// An accepted poll is registered in the input stage, then steps the phase machine; the new state is the result.
// Throughput: one poll per cycle unless result back-pressure stalls it; the phase machine steps once per accepted poll.
// Reset (rst_n low, asynchronous): phase empty, codes and stamp zero,
// key_enable all ones, hold_ms zero, no item in flight.
`default_nettype none

module button_press_hold_detector_core #(
    parameter int unsigned LINES = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bphd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [bphd_pkg::DATA_W-1:0] pwdata,
    output logic      [bphd_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    input  wire logic                        poll_valid,
    output logic                             poll_ready,
    input  wire logic [bphd_pkg::DATA_W-1:0] line_levels,
    input  wire logic [bphd_pkg::DATA_W-1:0] now_ms,
    output logic                             result_valid,
    input  wire logic                        result_ready,
    output logic      [bphd_pkg::DATA_W-1:0] key_code,
    output logic      [2:0]                  phase,
    output logic      [bphd_pkg::DATA_W-1:0] previous_code
);
    import bphd_pkg::*;

    localparam logic [DATA_W-1:0] LINE_MASK = DATA_W'((64'd1 << LINES) - 64'd1);

    logic [DATA_W-1:0] key_enable_reg;
    logic [DATA_W-1:0] hold_ms_reg;
    logic              cfg_write;

    logic              poll_valid_reg;
    logic [DATA_W-1:0] line_levels_reg;
    logic [DATA_W-1:0] now_ms_reg;
    logic              result_valid_reg;
    logic              advance;
    logic [DATA_W-1:0] code;
    bphd_state_t       state;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_enable_reg <= '1;
            hold_ms_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_KEY_ENABLE: key_enable_reg <= pwdata;
                REG_HOLD_MS:    hold_ms_reg    <= pwdata;
                default:        key_enable_reg <= key_enable_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_KEY_ENABLE: prdata = key_enable_reg;
            REG_HOLD_MS:    prdata = hold_ms_reg;
            default:        prdata = '0;
        endcase
    end

    // the result stage is the state itself; step when it is free or being taken
    assign advance    = poll_valid_reg && (!result_valid_reg || result_ready);
    assign poll_ready = !poll_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (poll_ready)
                poll_valid_reg <= poll_valid;
            if (advance)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll_ready && poll_valid)
        begin
            line_levels_reg <= line_levels;
            now_ms_reg      <= now_ms;
        end
    end

    assign code = ~line_levels_reg & key_enable_reg & LINE_MASK;

    bphd_fsm u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .code    (code),
        .now     (now_ms_reg),
        .hold_ms (hold_ms_reg),
        .state   (state)
    );

    assign result_valid  = result_valid_reg;
    assign key_code      = state.key_code;
    assign phase         = 3'(state.phase);
    assign previous_code = state.previous_code;

endmodule

`default_nettype wire

// File: tb/tb_button_press_hold_detector_core.sv
`timescale 1ns / 100ps
`default_nettype none

module tb_button_press_hold_detector_core;
    import bphd_pkg::*;

    localparam int unsigned LINES       = 32;
    localparam logic [31:0] LINE_BITS   = (LINES >= 32) ? 32'hFFFF_FFFF
                                                        : ((32'd1 << LINES) - 32'd1);
    localparam int          STALL_LIMIT = 5000;

    typedef struct packed {
        logic [31:0] key;
        phase_t      ph;
        logic [31:0] prev;
    } poll_result_t;

    class result_scoreboard;
        logic [31:0]  key_enable;
        logic [31:0]  hold_ms;
        phase_t       ph;
        logic [31:0]  cur_key;
        logic [31:0]  prev_key;
        logic [31:0]  stamp;
        poll_result_t expected_q[$];
        int           errors;
        int           checked;
        int           holds_seen;

        function new();
            key_enable  = 32'hFFFF_FFFF;
            hold_ms     = 32'd0;
            ph          = PH_EMPTY;
            cur_key     = 32'd0;
            prev_key    = 32'd0;
            stamp       = 32'd0;
            errors      = 0;
            checked     = 0;
            holds_seen  = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] value);
            if (idx == REG_KEY_ENABLE)
                key_enable = value;
            else
                hold_ms = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // step the phase machine for one accepted poll
        function void note_poll(logic [31:0] levels, logic [31:0] now);
            logic [31:0]  code;
            poll_result_t r;
            code = ~levels & key_enable & LINE_BITS;
            case (ph)
                PH_EMPTY:
                    if (code != 32'd0)
                    begin
                        prev_key = cur_key;
                        cur_key  = code;
                        ph       = PH_PRESSED;
                    end
                PH_PRESSED:
                    if (code == 32'd0)
                        ph = PH_RELEASED;
                    else if (code == cur_key)
                    begin
                        stamp = now;
                        ph    = PH_TIMING;
                    end
                    else
                        ph = PH_RELEASED;
                PH_TIMING:
                    if (code == 32'd0)
                        ph = PH_RELEASED;
                    else if ((now - stamp) > hold_ms)
                    begin
                        ph = PH_HOLD;
                        holds_seen++;
                    end
                PH_HOLD:
                    if (code == 32'd0)
                        ph = PH_RELEASED;
                PH_RELEASED:
                begin
                    prev_key = cur_key;
                    cur_key  = 32'd0;
                    ph       = PH_EMPTY;
                end
                default: ;
            endcase
            r.key  = cur_key;
            r.ph   = ph;
            r.prev = prev_key;
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [31:0] key, logic [2:0] ph_out, logic [31:0] prev);
            poll_result_t r;
            if (expected_q.size() == 0)
            begin
                $error("result with no poll waiting: key_code %h phase %0d previous_code %h",
                       key, ph_out, prev);
                errors++;
                return;
            end
            r = expected_q.pop_front();
            checked++;
            if (key !== r.key)
            begin
                $error("key_code: expected %h, got %h", r.key, key);
                errors++;
            end
            if (ph_out !== 3'(r.ph))
            begin
                $error("phase: expected %0d, got %0d", r.ph, ph_out);
                errors++;
            end
            if (prev !== r.prev)
            begin
                $error("previous_code: expected %h, got %h", r.prev, prev);
                errors++;
            end
        endfunction
    endclass

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [ADDR_W-1:0]   paddr         = '0;
    logic [DATA_W-1:0]   pwdata        = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                poll_valid    = 1'b0;
    logic                poll_ready;
    logic [DATA_W-1:0]   line_levels   = '1;
    logic [DATA_W-1:0]   now_ms        = '0;
    logic                result_valid;
    logic                result_ready  = 1'b0;
    logic [DATA_W-1:0]   key_code;
    logic [2:0]          phase;
    logic [DATA_W-1:0]   previous_code;

    result_scoreboard sb = new();

    int          src_idle_pct = 31;
    int          snk_idle_pct = 65;
    int          polls_sent   = 0;
    int          settings_run = 0;
    int          stall_cycles = 0;
    logic [31:0] clock_ms     = 32'd0;

    button_press_hold_detector_core #(
        .LINES(LINES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .poll_valid   (poll_valid),
        .poll_ready   (poll_ready),
        .line_levels  (line_levels),
        .now_ms       (now_ms),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .key_code     (key_code),
        .phase        (phase),
        .previous_code(previous_code)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
        result_ready <= ($urandom_range(99) >= snk_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(key_code, phase, previous_code);
    end

    always @(posedge clk)
    begin
        if ((poll_valid && poll_ready) || (result_valid && result_ready))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic set_idling(int mode);
        case (mode)
            0:
            begin
                src_idle_pct = 31;
                snk_idle_pct = 65;
            end
            1:
            begin
                src_idle_pct = 65;
                snk_idle_pct = 31;
            end
            default:
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
        endcase
    endtask

    // enter and leave at a falling edge
    task automatic send_poll(logic [31:0] levels, logic [31:0] now);
        bit accepted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            poll_valid <= 1'b0;
            @(negedge clk);
        end
        poll_valid  <= 1'b1;
        line_levels <= levels;
        now_ms      <= now;
        accepted = 1'b0;
        while (!accepted)
        begin
            @(posedge clk);
            accepted = poll_ready;
            if (accepted)
            begin
                sb.note_poll(levels, now);
                polls_sent++;
            end
            @(negedge clk);
        end
    endtask

    task automatic apb_write(logic idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // leave the bus idle before the next transfer
        @(negedge clk);
    endtask

    // drain all results, then rewrite both registers
    task automatic configure(logic [31:0] mask, logic [31:0] hold);
        poll_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        apb_write(REG_KEY_ENABLE, mask);
        apb_write(REG_HOLD_MS, hold);
        settings_run++;
    endtask

    // lines for a pressed code; lines outside the mask are random
    function automatic logic [31:0] levels_for(logic [31:0] code);
        logic [31:0] m;
        m = sb.key_enable & LINE_BITS;
        return (~code & m) | ($urandom & ~m);
    endfunction

    function automatic logic [31:0] pick_key();
        logic [31:0] k;
        logic [31:0] m;
        m = sb.key_enable & LINE_BITS;
        case ($urandom_range(2))
            0:       k = 32'd1 << $urandom_range(31);
            1:       k = $urandom;
            default: k = 32'hFFFF_FFFF;
        endcase
        k = k & m;
        if (k == 32'd0)
            k = m & (~m + 32'd1);
        return k;
    endfunction

    task automatic press_sequence();
        logic [31:0] k;
        int          n;
        k = pick_key();
        send_poll(levels_for(k), clock_ms);
        // bounce to another key right after the first press
        if ($urandom_range(99) < 15)
            send_poll(levels_for(pick_key()), clock_ms);
        n = $urandom_range(1, 12);
        repeat (n)
        begin
            clock_ms = clock_ms + 32'($urandom_range(0, 12));
            if ($urandom_range(99) < 10)
                send_poll(levels_for(pick_key()), clock_ms);
            else
                send_poll(levels_for(k), clock_ms);
        end
        n = $urandom_range(1, 3);
        repeat (n)
        begin
            clock_ms = clock_ms + 32'($urandom_range(0, 3));
            send_poll(levels_for(32'd0), clock_ms);
        end
    endtask

    initial
    begin
        int          seg;
        int          target;
        logic [31:0] mask;
        logic [31:0] hold;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // reset config: every line a button, hold after any nonzero elapsed time
        set_idling(0);
        send_poll(32'hFFFF_FFFF, 32'h0000_0000);
        send_poll(32'h0000_0000, 32'hFFFF_FFFF);
        send_poll(32'h0000_0000, 32'hFFFF_FFFF);
        // elapsed time wraps past zero
        send_poll(32'h0000_0000, 32'h0000_0000);
        send_poll(32'h0000_0000, 32'h0000_0005);
        send_poll(32'hFFFF_FFFF, 32'h0000_0006);
        send_poll(32'hFFFF_FFFF, 32'h0000_0007);
        // changed key while pressed
        send_poll(~32'h0000_0001, 32'd10);
        send_poll(~32'h0000_0002, 32'd11);
        send_poll(~32'h0000_0002, 32'd12);
        send_poll(~32'h8000_0000, 32'd100);
        send_poll(~32'h8000_0000, 32'd100);
        send_poll(~32'h8000_0000, 32'd100);
        // other key while timing stays in timing
        send_poll(~32'h0000_0003, 32'd100);
        send_poll(32'hFFFF_FFFF, 32'd101);
        // a press in released is dropped
        send_poll(~32'h0000_0005, 32'd102);
        send_poll(~32'h0000_0005, 32'd103);
        send_poll(32'hFFFF_FFFF, 32'd104);
        send_poll(32'hFFFF_FFFF, 32'd105);

        configure(32'h0000_0000, 32'hFFFF_FFFF);
        send_poll(32'h0000_0000, 32'd0);
        configure(32'h0000_FFFF, 32'hFFFF_FFFF);
        send_poll(32'h0000_0000, 32'd0);
        send_poll(32'h0000_0000, 32'd5);
        // elapsed of all ones never exceeds the largest hold time
        send_poll(32'h0000_0000, 32'd4);
        send_poll(32'hFFFF_00F0, 32'd4);
        send_poll(32'h0000_FFFF, 32'd4);
        send_poll(32'h0000_FFFF, 32'd4);

        for (seg = 0; seg < 6; seg++)
        begin
            case (seg)
                0:
                begin
                    mask = 32'hFFFF_FFFF;
                    hold = 32'd0;
                end
                1:
                begin
                    mask = $urandom | 32'd1;
                    hold = 32'd7;
                end
                2:
                begin
                    mask = 32'h0000_00FF;
                    hold = 32'd25;
                end
                3:
                begin
                    mask = 32'h8000_0001;
                    hold = 32'd1;
                end
                4:
                begin
                    mask = 32'hFFFF_FFFF;
                    hold = 32'hFFFF_FFFF;
                end
                default:
                begin
                    mask = $urandom;
                    hold = 32'($urandom_range(0, 30));
                end
            endcase
            configure(mask, hold);
            set_idling(seg / 2);
            // run time across the wrap in this setting
            if (seg == 2)
                clock_ms = 32'hFFFF_FF80;
            else
                clock_ms = $urandom;
            target = polls_sent + 72;
            while (polls_sent < target)
            begin
                if ($urandom_range(99) < 75)
                    press_sequence();
                else
                    send_poll($urandom, $urandom);
            end
        end

        poll_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Ran %0d polls over %0d mask/hold settings and three idling patterns;",
                 polls_sent, settings_run + 1);
        $display("checked %0d results, %0d of them entering hold.",
                 sb.checked, sb.holds_seen);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
